### src/slf_pkg.sv
// shared types and constants for the sequence line formatter
// no dependencies; imported by every module of the block
package slf_pkg;

   // width of the running base count field, in decimal digits
   localparam int NUMBER_DIGITS = 8;
   localparam int BCD_W = 4 * NUMBER_DIGITS;
   localparam int DIGIT_IDX_W = (NUMBER_DIGITS > 1) ? $clog2(NUMBER_DIGITS) : 1;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 7;

   // layout register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LEFT_MARGIN    = 2'd0,
      CSR_GROUP_WIDTH    = 2'd1,
      CSR_BASES_PER_LINE = 2'd2,
      CSR_NUMBER_COLUMN  = 2'd3
   } csr_index_type;

   localparam int DESC_DEPTH = 4;
   localparam int DESC_PTR_W = $clog2(DESC_DEPTH);

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_NEWLINE = 8'h0a;
   localparam logic [7:0] CH_ZERO = 8'h30;

   localparam logic [6:0] RUN_MAX = 7'd127;

   // one classified item, handed from the front to the back
   typedef struct packed {
      logic [7:0]       ch;
      logic [3:0]       margin_n;
      logic             close;
      logic             gspace;
      logic [6:0]       pad_n;
      logic [BCD_W-1:0] bcd;
      logic             wrapped;
      logic             last;
      logic             err;
   } desc_type;

   // one character run on the result side
   typedef struct packed {
      logic [7:0] out_char;
      logic [6:0] repeat_count;
      logic       run_last;
      logic       seq_end;
      logic       layout_error;
   } run_type;

endpackage

### src/slf_front.sv
// front end: config registers, line/group/column/count tracking
// turns each accepted base into a descriptor; depends on slf_pkg
module slf_front
   import slf_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data,
   input  logic                   accept,
   input  logic [7:0]             base_char,
   input  logic                   is_last,
   output desc_type               desc_out
);

   localparam logic [3:0] LEFT_MARGIN_RESET = 4'd5;
   localparam logic [5:0] GROUP_WIDTH_RESET = 6'd10;
   localparam logic [6:0] BASES_PER_LINE_RESET = 7'd60;
   localparam logic [6:0] NUMBER_COLUMN_RESET = 7'd72;
   localparam logic [6:0] COLUMN_MAX = 7'd127;

   logic [3:0] left_margin_ff, left_margin_in;
   logic [5:0] group_width_ff, group_width_in;
   logic [6:0] bases_per_line_ff, bases_per_line_in;
   logic [6:0] number_column_ff, number_column_in;

   logic [6:0]       line_fill_ff, line_fill_in;
   logic [5:0]       group_fill_ff, group_fill_in;
   logic [6:0]       out_column_ff, out_column_in;
   logic             column_over_ff, column_over_in;
   logic [BCD_W-1:0] count_bcd_ff, count_bcd_in;
   logic             count_wrapped_ff, count_wrapped_in;

   logic             line_start;
   logic [3:0]       margin_n;
   logic [7:0]       col_sum;
   logic [6:0]       col1;
   logic             over1;
   logic [7:0]       col_gs;
   logic [6:0]       line_fill1;
   logic [5:0]       group_fill1;
   logic             close;
   logic             group_full;
   logic             err;
   logic [6:0]       pad_n;
   logic [BCD_W-1:0] bcd1;
   logic             wrapped1;
   logic             carry;
   logic [3:0]       digit;

   always_comb begin
      left_margin_in = left_margin_ff;
      group_width_in = group_width_ff;
      bases_per_line_in = bases_per_line_ff;
      number_column_in = number_column_ff;
      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_LEFT_MARGIN:    left_margin_in = csr_write_data[3:0];
            CSR_GROUP_WIDTH:    group_width_in = csr_write_data[5:0];
            CSR_BASES_PER_LINE: bases_per_line_in = csr_write_data[6:0];
            CSR_NUMBER_COLUMN:  number_column_in = csr_write_data[6:0];
         endcase
      end
   end

   always_comb begin
      line_start = (line_fill_ff == 7'd0);
      margin_n = line_start ? left_margin_ff : 4'd0;
      // column after margin and base, saturating at the last column
      col_sum = (line_start ? 8'd0 : {1'b0, out_column_ff}) + {4'd0, margin_n} + 8'd1;
      col1 = col_sum[7] ? COLUMN_MAX : col_sum[6:0];
      over1 = (!line_start && column_over_ff) || col_sum[7];
      col_gs = {1'b0, col1} + 8'd1;

      line_fill1 = line_fill_ff + 7'd1;
      group_fill1 = group_fill_ff + 6'd1;
      close = is_last || (line_fill1 >= bases_per_line_ff);
      group_full = (group_fill1 >= group_width_ff);
      err = over1 || (col1 > number_column_ff);
      pad_n = err ? 7'd0 : (number_column_ff - col1);

      // decimal increment, ripple over the digits
      bcd1 = count_bcd_ff;
      carry = 1'b1;
      for (int i = 0; i < NUMBER_DIGITS; i++) begin
         digit = count_bcd_ff[4*i +: 4];
         if (carry) begin
            if (digit < 4'd9) begin
               bcd1[4*i +: 4] = digit + 4'd1;
               carry = 1'b0;
            end else begin
               bcd1[4*i +: 4] = 4'd0;
            end
         end
      end
      wrapped1 = count_wrapped_ff || carry;
   end

   always_comb begin
      line_fill_in = line_fill_ff;
      group_fill_in = group_fill_ff;
      out_column_in = out_column_ff;
      column_over_in = column_over_ff;
      count_bcd_in = count_bcd_ff;
      count_wrapped_in = count_wrapped_ff;
      if (accept) begin
         if (close) begin
            line_fill_in = 7'd0;
            if (is_last) begin
               group_fill_in = 6'd0;
               out_column_in = 7'd0;
               column_over_in = 1'b0;
               count_bcd_in = '0;
               count_wrapped_in = 1'b0;
            end else begin
               // a group that fills at the line end emits no space
               group_fill_in = group_full ? 6'd0 : group_fill1;
               out_column_in = col1;
               column_over_in = over1;
               count_bcd_in = bcd1;
               count_wrapped_in = wrapped1;
            end
         end else begin
            line_fill_in = line_fill1;
            count_bcd_in = bcd1;
            count_wrapped_in = wrapped1;
            if (group_full) begin
               group_fill_in = 6'd0;
               out_column_in = col_gs[7] ? COLUMN_MAX : col_gs[6:0];
               column_over_in = over1 || col_gs[7];
            end else begin
               group_fill_in = group_fill1;
               out_column_in = col1;
               column_over_in = over1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_margin_ff <= LEFT_MARGIN_RESET;
         group_width_ff <= GROUP_WIDTH_RESET;
         bases_per_line_ff <= BASES_PER_LINE_RESET;
         number_column_ff <= NUMBER_COLUMN_RESET;
         line_fill_ff <= 7'd0;
         group_fill_ff <= 6'd0;
         out_column_ff <= 7'd0;
         column_over_ff <= 1'b0;
         count_bcd_ff <= '0;
         count_wrapped_ff <= 1'b0;
      end else begin
         left_margin_ff <= left_margin_in;
         group_width_ff <= group_width_in;
         bases_per_line_ff <= bases_per_line_in;
         number_column_ff <= number_column_in;
         line_fill_ff <= line_fill_in;
         group_fill_ff <= group_fill_in;
         out_column_ff <= out_column_in;
         column_over_ff <= column_over_in;
         count_bcd_ff <= count_bcd_in;
         count_wrapped_ff <= count_wrapped_in;
      end
   end

   always_comb begin
      desc_out.ch = base_char;
      desc_out.margin_n = margin_n;
      desc_out.close = close;
      desc_out.gspace = !close && group_full;
      desc_out.pad_n = pad_n;
      desc_out.bcd = bcd1;
      desc_out.wrapped = wrapped1;
      desc_out.last = is_last;
      // overrun only counts on the base that closes the line
      desc_out.err = close && err;
   end

endmodule

### src/slf_desc_queue.sv
// short descriptor queue between front and back
// depends on slf_pkg for desc_type and depth
module slf_desc_queue
   import slf_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  desc_type desc_in,
   output logic     full,
   input  logic     pop,
   output logic     valid,
   output desc_type desc_out
);

   localparam logic [DESC_PTR_W:0] DEPTH_COUNT = (DESC_PTR_W + 1)'(DESC_DEPTH);

   desc_type entries_ff [DESC_DEPTH];
   logic [DESC_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [DESC_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [DESC_PTR_W:0]   count_ff, count_in;
   logic                  do_push;
   logic                  do_pop;

   always_comb begin
      full = (count_ff == DEPTH_COUNT);
      valid = (count_ff != '0);
      do_push = push && !full;
      do_pop = pop && valid;
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff + (DESC_PTR_W + 1)'(do_push) - (DESC_PTR_W + 1)'(do_pop);
      desc_out = entries_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= desc_in;
      end
   end

endmodule

### src/slf_back.sv
// back end: walks a descriptor piece by piece and merges pieces into runs
// depends on slf_pkg; writes runs into the result buffer
module slf_back
   import slf_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     desc_valid,
   input  desc_type desc_in,
   output logic     desc_pop,
   input  logic     run_ready,
   output logic     run_write,
   output run_type  run_out
);

   typedef enum logic [6:0] {
      PH_START   = 7'b0000001,
      PH_CHAR    = 7'b0000010,
      PH_PAD     = 7'b0000100,
      PH_LEAD    = 7'b0001000,
      PH_DIGIT   = 7'b0010000,
      PH_NEWLINE = 7'b0100000,
      PH_GSPACE  = 7'b1000000
   } phase_type;

   localparam logic [DIGIT_IDX_W-1:0] TOP_IDX = DIGIT_IDX_W'(NUMBER_DIGITS - 1);

   phase_type phase_ff, phase_in;
   logic [DIGIT_IDX_W-1:0] digit_idx_ff, digit_idx_in;
   logic [7:0] acc_ch_ff, acc_ch_in;
   logic [6:0] acc_n_ff, acc_n_in;
   logic       acc_valid_ff, acc_valid_in;
   logic       acc_done_ff, acc_done_in;
   logic       acc_err_ff, acc_err_in;
   logic       acc_seq_ff, acc_seq_in;

   logic [DIGIT_IDX_W:0]   lead;
   logic                   found;
   logic [DIGIT_IDX_W-1:0] first_idx;
   logic [3:0]             digit;
   phase_type              eff;
   phase_type              nxt;
   logic [7:0]             pc;
   logic [6:0]             pn;
   logic                   done;
   logic                   is_nl;
   logic                   step;
   logic                   flush;
   logic                   same;
   logic [7:0]             sum;

   // leading zero digits of the count show as spaces until it wraps
   always_comb begin
      lead = '0;
      found = desc_in.wrapped;
      for (int i = NUMBER_DIGITS - 1; i >= 0; i--) begin
         if (!found && desc_in.bcd[4*i +: 4] == 4'd0) begin
            lead = lead + 1'b1;
         end else begin
            found = 1'b1;
         end
      end
      first_idx = TOP_IDX - lead[DIGIT_IDX_W-1:0];
      digit = desc_in.bcd[4*digit_idx_ff +: 4];
   end

   // current piece and where the walk goes next
   always_comb begin
      eff = (phase_ff == PH_START && desc_in.margin_n == 4'd0) ? PH_CHAR : phase_ff;
      pc = CH_SPACE;
      pn = 7'd1;
      done = 1'b0;
      nxt = phase_ff;
      unique case (eff)
         PH_START: begin
            pn = {3'd0, desc_in.margin_n};
            nxt = PH_CHAR;
         end
         PH_CHAR: begin
            pc = desc_in.ch;
            if (desc_in.close) begin
               if (desc_in.pad_n != 7'd0) begin
                  nxt = PH_PAD;
               end else if (lead != '0) begin
                  nxt = PH_LEAD;
               end else begin
                  nxt = PH_DIGIT;
               end
            end else if (desc_in.gspace) begin
               nxt = PH_GSPACE;
            end else begin
               done = 1'b1;
            end
         end
         PH_PAD: begin
            pn = desc_in.pad_n;
            nxt = (lead != '0) ? PH_LEAD : PH_DIGIT;
         end
         PH_LEAD: begin
            pn = 7'(lead);
            nxt = PH_DIGIT;
         end
         PH_DIGIT: begin
            pc = CH_ZERO + {4'd0, digit};
            nxt = (digit_idx_ff == '0) ? PH_NEWLINE : PH_DIGIT;
         end
         PH_NEWLINE: begin
            pc = CH_NEWLINE;
            done = 1'b1;
         end
         PH_GSPACE: begin
            done = 1'b1;
         end
         default: begin
            done = 1'b1;
         end
      endcase
      if (done) begin
         nxt = PH_START;
      end
      is_nl = (eff == PH_NEWLINE);
   end

   always_comb begin
      step = desc_valid && run_ready;
      // finished item with nothing behind it goes out on its own
      flush = !desc_valid && acc_valid_ff && acc_done_ff && run_ready;
      same = acc_valid_ff && !acc_done_ff && (acc_ch_ff == pc) && (acc_n_ff != RUN_MAX);
      sum = {1'b0, acc_n_ff} + {1'b0, pn};

      phase_in = phase_ff;
      digit_idx_in = digit_idx_ff;
      acc_ch_in = acc_ch_ff;
      acc_n_in = acc_n_ff;
      acc_valid_in = acc_valid_ff;
      acc_done_in = acc_done_ff;
      acc_err_in = acc_err_ff;
      acc_seq_in = acc_seq_ff;

      run_write = 1'b0;
      run_out.out_char = acc_ch_ff;
      run_out.repeat_count = acc_n_ff;
      run_out.run_last = acc_done_ff;
      run_out.seq_end = acc_seq_ff && acc_done_ff;
      run_out.layout_error = acc_err_ff;

      if (step) begin
         if (same) begin
            if (!sum[7]) begin
               acc_n_in = sum[6:0];
            end else begin
               // run is full, the remainder opens a new one
               run_write = 1'b1;
               run_out.repeat_count = RUN_MAX;
               run_out.run_last = 1'b0;
               run_out.seq_end = 1'b0;
               acc_n_in = 7'(sum - 8'd127);
            end
         end else begin
            run_write = acc_valid_ff;
            acc_ch_in = pc;
            acc_n_in = pn;
            acc_valid_in = 1'b1;
            acc_err_in = desc_in.err;
            acc_seq_in = is_nl && desc_in.last;
         end
         acc_done_in = done;
         phase_in = nxt;
         if (eff == PH_DIGIT) begin
            digit_idx_in = digit_idx_ff - 1'b1;
         end else if (nxt == PH_DIGIT) begin
            digit_idx_in = first_idx;
         end
      end else if (flush) begin
         run_write = 1'b1;
         acc_valid_in = 1'b0;
         acc_done_in = 1'b0;
      end
      desc_pop = step && done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_START;
         acc_valid_ff <= 1'b0;
         acc_done_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         acc_valid_ff <= acc_valid_in;
         acc_done_ff <= acc_done_in;
      end
   end

   always_ff @(posedge clock) begin
      digit_idx_ff <= digit_idx_in;
      acc_ch_ff <= acc_ch_in;
      acc_n_ff <= acc_n_in;
      acc_err_ff <= acc_err_in;
      acc_seq_ff <= acc_seq_in;
   end

endmodule

### src/slf_rsp_fifo.sv
// two-entry result buffer in front of the result ports
// depends on slf_pkg for run_type
module slf_rsp_fifo
   import slf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    write,
   input  run_type run_in,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output run_type run_out
);

   run_type entries_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_write;
   logic       do_pop;

   always_comb begin
      full = (count_ff == 2'd2);
      empty = (count_ff == 2'd0);
      do_write = write && !full;
      do_pop = pop && !empty;
      wr_ptr_in = do_write ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in = count_ff + 2'(do_write) - 2'(do_pop);
      run_out = entries_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_write) begin
         entries_ff[wr_ptr_ff] <= run_in;
      end
   end

endmodule

### src/embl_sequence_line_formatter.sv
// Formats a stream of sequence bases into EMBL-style text lines given as character runs
// (a character and a repeat count). A base is taken whenever full is low; the front end
// classifies it in the cycle it is accepted and parks it in a four-deep queue, so intake
// is one base per cycle until that queue fills. The back end emits one piece per cycle
// while the result buffer has room: a base inside a line is one piece, with one more when
// a group space follows and one more for a nonzero margin at a line start, and a line end
// adds the padding and the lead spaces when there are any, one piece per shown digit (up
// to NUMBER_DIGITS) and one for the newline. Sustained throughput is therefore set by the
// back end's piece walk. Results leave through a two-entry buffer, one run per cycle
// while pop is held high; the final run of a base is held until the next base's first
// piece or until the back end goes idle.
// depends on slf_pkg, slf_front, slf_desc_queue, slf_back, slf_rsp_fifo
module embl_sequence_line_formatter
   import slf_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   output logic                   full,
   input  logic [7:0]             req_base_char,
   input  logic                   req_is_last,
   output logic                   empty,
   input  logic                   pop,
   output logic [7:0]             rsp_out_char,
   output logic [6:0]             rsp_repeat_count,
   output logic                   rsp_run_last,
   output logic                   rsp_seq_end,
   output logic                   rsp_layout_error,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   logic     accept;
   desc_type front_desc;
   desc_type queue_desc;
   logic     desc_valid;
   logic     desc_pop;
   logic     rsp_full;
   logic     run_write;
   run_type  back_run;
   run_type  rsp_run;

   assign accept = push && !full;

   slf_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .accept           (accept),
      .base_char        (req_base_char),
      .is_last          (req_is_last),
      .desc_out         (front_desc)
   );

   slf_desc_queue u_desc_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (accept),
      .desc_in  (front_desc),
      .full     (full),
      .pop      (desc_pop),
      .valid    (desc_valid),
      .desc_out (queue_desc)
   );

   slf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .desc_valid (desc_valid),
      .desc_in    (queue_desc),
      .desc_pop   (desc_pop),
      .run_ready  (!rsp_full),
      .run_write  (run_write),
      .run_out    (back_run)
   );

   slf_rsp_fifo u_rsp_fifo (
      .clock   (clock),
      .reset   (reset),
      .write   (run_write),
      .run_in  (back_run),
      .full    (rsp_full),
      .pop     (pop),
      .empty   (empty),
      .run_out (rsp_run)
   );

   assign rsp_out_char = rsp_run.out_char;
   assign rsp_repeat_count = rsp_run.repeat_count;
   assign rsp_run_last = rsp_run.run_last;
   assign rsp_seq_end = rsp_run.seq_end;
   assign rsp_layout_error = rsp_run.layout_error;

   // the sequence ends only on a newline that closes its item
   a_seq_end_newline: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_seq_end) |-> (rsp_run_last && rsp_out_char == CH_NEWLINE))
      else $error("seq_end on a run that is not the closing newline");

   a_run_not_empty: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_repeat_count != 7'd0))
      else $error("result run with zero repeat count");

   a_pop_when_valid: assert property (@(posedge clock) disable iff (reset)
      desc_pop |-> desc_valid)
      else $error("back end finished an item with the queue empty");

   a_write_has_room: assert property (@(posedge clock) disable iff (reset)
      run_write |-> !rsp_full)
      else $error("run written into a full result buffer");

endmodule

### tb/tb_embl_sequence_line_formatter.sv
// testbench for embl_sequence_line_formatter: directed table, then random base sequences
// over several layouts, every result run checked against typed rows or an in-bench layout predictor
// depends on slf_pkg and the embl_sequence_line_formatter rtl
module tb_embl_sequence_line_formatter
   import slf_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RUN_SLOTS = NUMBER_DIGITS + 8;
   localparam int RANDOM_ITEMS = 260;
   localparam int FINAL_ITEMS = 40;
   localparam int SETTLE_CYCLES = 24;
   localparam int TAIL_CYCLES = 40;
   localparam int STALL_LIMIT = 4000;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type                kind;
      logic [CSR_INDEX_W-1:0]      reg_idx;
      logic [CSR_DATA_W-1:0]       reg_val;
      logic [7:0]                  ch;
      logic                        last;
      logic [2:0]                  n_typed;
      run_type [3:0]               typed;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic push = 1'b0;
   logic [7:0] req_base_char = 8'h00;
   logic req_is_last = 1'b0;
   logic pop = 1'b0;
   logic csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;
   logic full;
   logic empty;
   logic [7:0] rsp_out_char;
   logic [6:0] rsp_repeat_count;
   logic rsp_run_last;
   logic rsp_seq_end;
   logic rsp_layout_error;

   embl_sequence_line_formatter dut (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_base_char    (req_base_char),
      .req_is_last      (req_is_last),
      .empty            (empty),
      .pop              (pop),
      .rsp_out_char     (rsp_out_char),
      .rsp_repeat_count (rsp_repeat_count),
      .rsp_run_last     (rsp_run_last),
      .rsp_seq_end      (rsp_seq_end),
      .rsp_layout_error (rsp_layout_error),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #1 clock = ~clock;

   // layout registers and line state as the formatter should hold them
   int cfg_margin = 5;
   int cfg_group = 10;
   int cfg_line_len = 60;
   int cfg_num_col = 72;
   logic [BCD_W-1:0] count_bcd = '0;
   int line_bases = 0;
   int group_bases = 0;
   int col = 0;
   bit count_wrapped = 1'b0;
   bit col_over = 1'b0;

   logic [7:0] run_chr [RUN_SLOTS];
   int run_len [RUN_SLOTS];
   int nruns;

   run_type expected_runs [$];
   run_type want_run;
   int mismatches = 0;
   int items_sent = 0;
   int stall_cycles = 0;
   int rx_hold = 0;
   bit gaps_on = 1'b1;

   function automatic run_type mk_run(logic [7:0] c, int n, logic rl, logic se, logic le);
      run_type r;
      r.out_char = c;
      r.repeat_count = 7'(n);
      r.run_last = rl;
      r.seq_end = se;
      r.layout_error = le;
      return r;
   endfunction

   function automatic stim_row_type item_row(logic [7:0] c, logic last);
      stim_row_type r;
      r = '0;
      r.kind = ROW_ITEM;
      r.ch = c;
      r.last = last;
      return r;
   endfunction

   function automatic stim_row_type csr_row(logic [CSR_INDEX_W-1:0] idx, int val);
      stim_row_type r;
      r = '0;
      r.kind = ROW_CSR;
      r.reg_idx = idx;
      r.reg_val = CSR_DATA_W'(val);
      return r;
   endfunction

   function automatic logic [7:0] pick_base();
      if ($urandom_range(0, 1) == 0) return 8'($urandom_range(0, 255));
      case ($urandom_range(0, 3))
         0: return 8'h41;
         1: return 8'h43;
         2: return 8'h47;
         default: return 8'h54;
      endcase
   endfunction

   task automatic apply_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      case (idx)
         CSR_LEFT_MARGIN: cfg_margin = int'(val[3:0]);
         CSR_GROUP_WIDTH: cfg_group = int'(val[5:0]);
         CSR_BASES_PER_LINE: cfg_line_len = int'(val[6:0]);
         CSR_NUMBER_COLUMN: cfg_num_col = int'(val[6:0]);
         default: ;
      endcase
   endtask

   // append n copies of c, merging into the previous run up to 127
   task automatic add_run(logic [7:0] c, int n);
      int take;
      while (n > 0) begin
         if (nruns > 0 && run_chr[nruns-1] == c && run_len[nruns-1] < 127) begin
            take = 127 - run_len[nruns-1];
            if (take > n) take = n;
            run_len[nruns-1] += take;
         end else begin
            if (nruns >= RUN_SLOTS) return;
            take = (n > 127) ? 127 : n;
            run_chr[nruns] = c;
            run_len[nruns] = take;
            nruns++;
         end
         n -= take;
      end
   endtask

   task automatic bump_col(int n);
      col += n;
      if (col > 127) begin
         col = 127;
         col_over = 1'b1;
      end
   endtask

   task automatic format_base(logic [7:0] ch, logic last, bit enqueue);
      logic err;
      int nl_at;
      int lead;
      int i;
      bit carry;
      run_type r;
      err = 1'b0;
      nl_at = -1;
      nruns = 0;
      if (line_bases == 0) begin
         col = 0;
         col_over = 1'b0;
         add_run(CH_SPACE, cfg_margin);
         bump_col(cfg_margin);
      end
      add_run(ch, 1);
      bump_col(1);
      line_bases = (line_bases + 1) & 8'h7f;
      group_bases = (group_bases + 1) & 8'h3f;
      carry = 1'b1;
      for (i = 0; i < NUMBER_DIGITS && carry; i++) begin
         if (count_bcd[4*i +: 4] < 4'd9) begin
            count_bcd[4*i +: 4] = count_bcd[4*i +: 4] + 4'd1;
            carry = 1'b0;
         end else begin
            count_bcd[4*i +: 4] = 4'd0;
         end
      end
      if (carry) count_wrapped = 1'b1;

      if (last || line_bases >= cfg_line_len) begin
         // content past the number column: count follows directly, no padding
         if (col_over || col > cfg_num_col) err = 1'b1;
         else add_run(CH_SPACE, cfg_num_col - col);
         lead = 0;
         if (!count_wrapped) begin
            while (lead < NUMBER_DIGITS && count_bcd[4*(NUMBER_DIGITS-1-lead) +: 4] == 4'd0)
               lead++;
         end
         add_run(CH_SPACE, lead);
         for (i = NUMBER_DIGITS - 1 - lead; i >= 0; i--)
            add_run(CH_ZERO + 8'(count_bcd[4*i +: 4]), 1);
         add_run(CH_NEWLINE, 1);
         nl_at = nruns - 1;
         line_bases = 0;
         // an unfinished group carries over to the next line
         if (group_bases >= cfg_group) group_bases = 0;
         if (last) begin
            count_bcd = '0;
            group_bases = 0;
            col = 0;
            count_wrapped = 1'b0;
            col_over = 1'b0;
         end
      end else if (group_bases >= cfg_group) begin
         add_run(CH_SPACE, 1);
         bump_col(1);
         group_bases = 0;
      end

      if (enqueue) begin
         for (i = 0; i < nruns; i++) begin
            r = mk_run(run_chr[i], run_len[i], i == nruns - 1, last && i == nl_at, err);
            expected_runs.push_back(r);
         end
      end
   endtask

   task automatic send_base(logic [7:0] ch, logic last, bit enqueue);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      push <= 1'b1;
      req_base_char <= ch;
      req_is_last <= last;
      @(posedge clock);
      while (full) @(posedge clock);
      items_sent++;
      format_base(ch, last, enqueue);
   endtask

   // registers change only once every run is out and the back end has gone quiet
   task automatic wait_idle();
      push <= 1'b0;
      while (expected_runs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, int val);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= CSR_DATA_W'(val);
      @(posedge clock);
      apply_reg(idx, CSR_DATA_W'(val));
   endtask

   task automatic write_layout(int m, int g, int l, int n);
      wait_idle();
      write_reg(CSR_LEFT_MARGIN, m);
      write_reg(CSR_GROUP_WIDTH, g);
      write_reg(CSR_BASES_PER_LINE, l);
      write_reg(CSR_NUMBER_COLUMN, n);
      csr_write_enable <= 1'b0;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
         rx_hold = 0;
      end else begin
         if (pop && !empty) begin
            if (expected_runs.size() == 0) begin
               $error("unexpected run: out_char %h repeat_count %0d",
                      rsp_out_char, rsp_repeat_count);
               mismatches++;
            end else begin
               want_run = expected_runs.pop_front();
               if (rsp_out_char !== want_run.out_char) begin
                  $error("out_char: expected %h, got %h", want_run.out_char, rsp_out_char);
                  mismatches++;
               end
               if (rsp_repeat_count !== want_run.repeat_count) begin
                  $error("repeat_count: expected %0d, got %0d",
                         want_run.repeat_count, rsp_repeat_count);
                  mismatches++;
               end
               if (rsp_run_last !== want_run.run_last) begin
                  $error("run_last: expected %b, got %b", want_run.run_last, rsp_run_last);
                  mismatches++;
               end
               if (rsp_seq_end !== want_run.seq_end) begin
                  $error("seq_end: expected %b, got %b", want_run.seq_end, rsp_seq_end);
                  mismatches++;
               end
               if (rsp_layout_error !== want_run.layout_error) begin
                  $error("layout_error: expected %b, got %b",
                         want_run.layout_error, rsp_layout_error);
                  mismatches++;
               end
            end
         end
         if (rx_hold > 0) begin
            rx_hold--;
            pop <= 1'b0;
         end else if (gaps_on && $urandom_range(0, 4) == 0) begin
            rx_hold = $urandom_range(1, 7) - 1;
            pop <= 1'b0;
         end else begin
            pop <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
   end

   initial begin
      while (stall_cycles < STALL_LIMIT) @(posedge clock);
      $display("Mismatches found");
      $finish;
   end

   initial begin
      stim_row_type dir_rows [$];
      stim_row_type row;
      int r;
      int k;
      int phase;
      int budget;
      int phase_start;
      int base_sent;
      int len;
      int max_len;
      int m;
      int g;
      int l;
      int n;
      bit held_once;

      // reset layout: margin then first base
      row = item_row(8'h41, 1'b0);
      row.n_typed = 3'd2;
      row.typed[0] = mk_run(CH_SPACE, 5, 1'b0, 1'b0, 1'b0);
      row.typed[1] = mk_run(8'h41, 1, 1'b1, 1'b0, 1'b0);
      dir_rows.push_back(row);
      dir_rows.push_back(item_row(CH_SPACE, 1'b0));
      dir_rows.push_back(item_row(8'hff, 1'b0));
      dir_rows.push_back(item_row(CH_NEWLINE, 1'b1));
      // minimum layout: every line overruns column zero
      dir_rows.push_back(csr_row(CSR_LEFT_MARGIN, 0));
      dir_rows.push_back(csr_row(CSR_GROUP_WIDTH, 1));
      dir_rows.push_back(csr_row(CSR_BASES_PER_LINE, 1));
      dir_rows.push_back(csr_row(CSR_NUMBER_COLUMN, 0));
      row = item_row(8'h47, 1'b1);
      row.n_typed = 3'd4;
      row.typed[0] = mk_run(8'h47, 1, 1'b0, 1'b0, 1'b1);
      row.typed[1] = mk_run(CH_SPACE, 7, 1'b0, 1'b0, 1'b1);
      row.typed[2] = mk_run(CH_ZERO + 8'd1, 1, 1'b0, 1'b0, 1'b1);
      row.typed[3] = mk_run(CH_NEWLINE, 1, 1'b1, 1'b1, 1'b1);
      dir_rows.push_back(row);
      dir_rows.push_back(item_row(8'h00, 1'b0));
      dir_rows.push_back(item_row(8'h7f, 1'b1));
      // zero group width and line length act as one; long space runs hit the merge cap
      dir_rows.push_back(csr_row(CSR_GROUP_WIDTH, 0));
      dir_rows.push_back(csr_row(CSR_BASES_PER_LINE, 0));
      dir_rows.push_back(csr_row(CSR_LEFT_MARGIN, 15));
      dir_rows.push_back(csr_row(CSR_NUMBER_COLUMN, 127));
      dir_rows.push_back(item_row(CH_SPACE, 1'b0));
      dir_rows.push_back(item_row(8'h54, 1'b0));
      dir_rows.push_back(item_row(8'h43, 1'b1));
      // group of four straddling lines of six
      dir_rows.push_back(csr_row(CSR_LEFT_MARGIN, 2));
      dir_rows.push_back(csr_row(CSR_GROUP_WIDTH, 4));
      dir_rows.push_back(csr_row(CSR_BASES_PER_LINE, 6));
      dir_rows.push_back(csr_row(CSR_NUMBER_COLUMN, 20));
      for (k = 0; k < 8; k++) dir_rows.push_back(item_row(8'h61 + 8'(k), k == 7));
      // group of three closing exactly at the line end
      dir_rows.push_back(csr_row(CSR_GROUP_WIDTH, 3));
      for (k = 0; k < 7; k++) dir_rows.push_back(item_row(8'h30 + 8'(k), k == 6));

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      gaps_on = 1'b1;
      for (r = 0; r < dir_rows.size(); r++) begin
         row = dir_rows[r];
         if (row.kind == ROW_CSR) begin
            if (r == 0 || dir_rows[r-1].kind != ROW_CSR) wait_idle();
            csr_write_enable <= 1'b1;
            csr_index <= row.reg_idx;
            csr_write_data <= row.reg_val;
            @(posedge clock);
            apply_reg(row.reg_idx, row.reg_val);
            if (r == dir_rows.size() - 1 || dir_rows[r+1].kind != ROW_CSR)
               csr_write_enable <= 1'b0;
         end else begin
            send_base(row.ch, row.last, row.n_typed == 0);
            for (k = 0; k < row.n_typed; k++) expected_runs.push_back(row.typed[k]);
         end
      end

      base_sent = items_sent;
      held_once = 1'b0;
      phase = 0;
      while (items_sent - base_sent < RANDOM_ITEMS - FINAL_ITEMS) begin
         case (phase)
            0: begin
               m = 0;
               g = 1;
               l = 1;
               n = 0;
            end
            1: begin
               m = 15;
               g = 63;
               l = 127;
               n = 127;
            end
            default: begin
               m = $urandom_range(0, 15);
               g = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 8) : $urandom_range(1, 63);
               l = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 127) : $urandom_range(1, 24);
               if ($urandom_range(0, 3) == 0) n = $urandom_range(0, 127);
               else n = m + l + l / g + $urandom_range(0, 10);
               if (n > 127) n = 127;
            end
         endcase
         write_layout(m, g, l, n);
         gaps_on = (phase < 2) || ($urandom_range(0, 3) != 0);
         max_len = (3 * l < 40) ? 3 * l : 40;
         phase_start = items_sent;
         budget = 40;
         if (phase == 1) begin
            // one long line that runs the output column past its limit
            budget = 150;
            for (k = 0; k < 130; k++) send_base(pick_base(), k == 129, 1'b1);
         end
         while (items_sent - phase_start < budget) begin
            if ($urandom_range(0, 9) == 0) begin
               send_base(pick_base(), 1'($urandom_range(0, 1)), 1'b1);
            end else begin
               len = $urandom_range(1, max_len);
               for (k = 0; k < len; k++) send_base(pick_base(), k == len - 1, 1'b1);
            end
            if ((!held_once && items_sent - base_sent >= 150) || $urandom_range(0, 59) == 0) begin
               push <= 1'b0;
               do @(posedge clock); while (expected_runs.size() != 0);
               held_once = 1'b1;
            end
         end
         phase++;
      end

      // back to the reset layout, full speed on both sides
      write_layout(5, 10, 60, 72);
      gaps_on = 1'b0;
      phase_start = items_sent;
      while (items_sent - phase_start < FINAL_ITEMS) begin
         len = $urandom_range(1, 40);
         for (k = 0; k < len; k++) send_base(pick_base(), k == len - 1, 1'b1);
      end

      push <= 1'b0;
      while (expected_runs.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_runs.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
